// ===== rtl/core/fdc_pkg.sv =====
// Shared types and constants for the curl-of-B stencil block.
package fdc_pkg;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [3:0]        mat_x;
    logic [3:0]        mat_y;
    logic [3:0]        mat_z;
    logic [3:0]        load_index;
    logic signed [31:0] load_rmu_x;
    logic signed [31:0] load_rmu_y;
    logic signed [31:0] load_rmu_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] curl_x;
    logic signed [31:0] curl_y;
    logic signed [31:0] curl_z;
    logic              neighbors_ok;
    logic [5:0]        at_x;
    logic [5:0]        at_y;
    logic [5:0]        at_z;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROD,
    S_DIFF,
    S_CURL,
    S_SAT
  } state_t;

  localparam logic CMD_VOXEL = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;
  localparam logic [CFG_IW-1:0] CFG_COEF_X  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_COEF_Y  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_COEF_Z  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CELLS_X = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_CELLS_Y = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_CELLS_Z = 3'd5;

  localparam int COEF_W     = 17;
  localparam int CELLS_W    = 7;
  localparam int COEF_FRAC  = 16;
  localparam logic [CELLS_W-1:0] CELLS_RESET = 7'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/core/fdtd_curl_b_stencil.sv =====
// Top level of the curl-of-B stencil: material tables, row and plane stores, curl datapath.
//
// Input requests arrive on in_valid/in_stall/in_data in raster order, x fastest.
// A request with cmd set loads one material table entry.
// A voxel request reads the tables and the row and plane stores, forms the
// three products on one shared 32x32 multiplier, the six neighbor differences,
// the six coefficient terms on one shared 33x18 multiplier and the saturated
// curls. Its result is registered once the output register is free; a new
// request is taken only after that, when the block is back in S_IDLE, so
// voxels do not overlap in the two shared multipliers. The output register
// is separate: a new request is accepted while a result waits under
// out_stall, and only the final step of the next voxel waits for that
// register to free up.
// After reset (rst_n low, synchronous) in_stall stays high while the plane
// and row stores are cleared; configuration writes are taken at any time
// and do not move the grid position.
module fdtd_curl_b_stencil #(
  parameter int MAX_X       = 64,
  parameter int MAX_Y       = 64,
  parameter int MAX_Z       = 64,
  parameter int N_MATERIALS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fdc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fdc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [fdc_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [fdc_pkg::CFG_DW-1:0]     cfg_data
);

  localparam int XW      = $clog2(MAX_X);
  localparam int YW      = $clog2(MAX_Y);
  localparam int ZW      = $clog2(MAX_Z);
  localparam int PLANE_D = MAX_X * MAX_Y;
  localparam int PAW     = $clog2(PLANE_D);
  localparam int MAW     = (N_MATERIALS > 1) ? $clog2(N_MATERIALS) : 1;
  localparam int XCW     = ($clog2(MAX_X + 1) > fdc_pkg::CELLS_W) ?
                           $clog2(MAX_X + 1) : fdc_pkg::CELLS_W;
  localparam int YCW     = ($clog2(MAX_Y + 1) > fdc_pkg::CELLS_W) ?
                           $clog2(MAX_Y + 1) : fdc_pkg::CELLS_W;
  localparam int ZCW     = ($clog2(MAX_Z + 1) > fdc_pkg::CELLS_W) ?
                           $clog2(MAX_Z + 1) : fdc_pkg::CELLS_W;

  fdc_pkg::state_t st_r, st_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [PAW-1:0]  clr_r, clr_nxt;

  logic [fdc_pkg::COEF_W-1:0]  coef_x_r, coef_y_r, coef_z_r;
  logic [fdc_pkg::CELLS_W-1:0] cells_x_r, cells_y_r, cells_z_r;

  logic [XW-1:0] pos_x_r;
  logic [YW-1:0] pos_y_r;
  logic [ZW-1:0] pos_z_r;
  logic signed [31:0] prev_a_r, prev_b_r;

  logic signed [31:0] b_r [3];
  logic [2:0]         mok_r;
  logic signed [63:0] mul_r;
  logic signed [31:0] p_r [3];
  logic signed [32:0] diff_r [6];
  logic signed [50:0] cm_r, acc_r;
  logic signed [51:0] sum_r [3];

  logic               out_valid_r;
  fdc_pkg::out_item_t out_data_r;

  logic in_acc, voxel_acc, load_acc, out_load;
  logic [8:0] mx9, my9, mz9, li9;
  logic tab_we;
  logic [31:0] tabx_q, taby_q, tabz_q;
  logic [63:0] row_q, plane_q, row_wdata, plane_wdata;
  logic row_we, plane_we;
  logic [XW-1:0]  row_waddr;
  logic [PAW-1:0] plane_waddr, pidx;

  logic signed [31:0] b_sel, rmu_sel;
  logic signed [32:0] diff_sel;
  logic [fdc_pkg::COEF_W-1:0] coef_sel;
  logic [2:0] term_j;
  logic [1:0] sum_j;
  logic ok;
  logic [XCW-1:0] cx_ext, len_x;
  logic [YCW-1:0] cy_ext, len_y;
  logic [ZCW-1:0] cz_ext, len_z;

  function automatic logic signed [31:0] sat_prod(input logic signed [63:0] v);
    logic signed [63:0] s;
    begin
      s = v >>> FRAC_BITS;
      if (s[63:31] == '0 || s[63:31] == '1) begin
        sat_prod = s[31:0];
      end else begin
        sat_prod = s[63] ? fdc_pkg::Q_MIN : fdc_pkg::Q_MAX;
      end
    end
  endfunction

  function automatic logic signed [31:0] sat_curl(input logic signed [51:0] v);
    logic signed [51:0] s;
    begin
      s = v >>> fdc_pkg::COEF_FRAC;
      if (s[51:31] == '0 || s[51:31] == '1) begin
        sat_curl = s[31:0];
      end else begin
        sat_curl = s[51] ? fdc_pkg::Q_MIN : fdc_pkg::Q_MAX;
      end
    end
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign voxel_acc = in_acc && (in_data.cmd == fdc_pkg::CMD_VOXEL);
  assign load_acc  = in_acc && (in_data.cmd == fdc_pkg::CMD_LOAD);

  assign mx9 = 9'(in_data.mat_x);
  assign my9 = 9'(in_data.mat_y);
  assign mz9 = 9'(in_data.mat_z);
  assign li9 = 9'(in_data.load_index);
  assign tab_we = load_acc && (li9 < 9'(N_MATERIALS));

  assign pidx = PAW'(pos_y_r) * PAW'(MAX_X) + PAW'(pos_x_r);
  assign ok   = (pos_x_r != '0) && (pos_y_r != '0) && (pos_z_r != '0);

  assign cx_ext = XCW'(cells_x_r);
  assign cy_ext = YCW'(cells_y_r);
  assign cz_ext = ZCW'(cells_z_r);
  assign len_x = (cx_ext < XCW'(2)) ? XCW'(2) : ((cx_ext > XCW'(MAX_X)) ? XCW'(MAX_X) : cx_ext);
  assign len_y = (cy_ext < YCW'(2)) ? YCW'(2) : ((cy_ext > YCW'(MAX_Y)) ? YCW'(MAX_Y) : cy_ext);
  assign len_z = (cz_ext < ZCW'(2)) ? ZCW'(2) : ((cz_ext > ZCW'(MAX_Z)) ? ZCW'(MAX_Z) : cz_ext);

  fdc_ram #(.WIDTH(32), .DEPTH(N_MATERIALS)) u_tab_x (
    .clk(clk), .we(tab_we), .waddr(li9[MAW-1:0]), .wdata(in_data.load_rmu_x),
    .re(voxel_acc), .raddr(mx9[MAW-1:0]), .rdata(tabx_q)
  );
  fdc_ram #(.WIDTH(32), .DEPTH(N_MATERIALS)) u_tab_y (
    .clk(clk), .we(tab_we), .waddr(li9[MAW-1:0]), .wdata(in_data.load_rmu_y),
    .re(voxel_acc), .raddr(my9[MAW-1:0]), .rdata(taby_q)
  );
  fdc_ram #(.WIDTH(32), .DEPTH(N_MATERIALS)) u_tab_z (
    .clk(clk), .we(tab_we), .waddr(li9[MAW-1:0]), .wdata(in_data.load_rmu_z),
    .re(voxel_acc), .raddr(mz9[MAW-1:0]), .rdata(tabz_q)
  );

  // row entry: {Px, Pz}; plane entry: {Px, Py}
  fdc_ram #(.WIDTH(64), .DEPTH(MAX_X)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(voxel_acc), .raddr(pos_x_r), .rdata(row_q)
  );
  fdc_ram #(.WIDTH(64), .DEPTH(PLANE_D)) u_plane (
    .clk(clk), .we(plane_we), .waddr(plane_waddr), .wdata(plane_wdata),
    .re(voxel_acc), .raddr(pidx), .rdata(plane_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= fdc_pkg::S_CLEAR;
      cnt_r <= '0;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    in_stall    = 1'b1;
    out_load    = 1'b0;
    row_we      = 1'b0;
    row_waddr   = pos_x_r;
    row_wdata   = {p_r[0], p_r[2]};
    plane_we    = 1'b0;
    plane_waddr = pidx;
    plane_wdata = {p_r[0], p_r[1]};
    case (st_r)
      fdc_pkg::S_CLEAR: begin
        row_we      = clr_r < PAW'(MAX_X);
        row_waddr   = clr_r[XW-1:0];
        row_wdata   = '0;
        plane_we    = 1'b1;
        plane_waddr = clr_r;
        plane_wdata = '0;
        clr_nxt     = clr_r + PAW'(1);
        if (clr_r == PAW'(PLANE_D - 1)) begin
          st_nxt = fdc_pkg::S_IDLE;
        end
      end
      fdc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
        if (voxel_acc) begin
          st_nxt = fdc_pkg::S_PROD;
        end
      end
      fdc_pkg::S_PROD: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          cnt_nxt = '0;
          st_nxt  = fdc_pkg::S_DIFF;
        end
      end
      fdc_pkg::S_DIFF: begin
        row_we   = 1'b1;
        plane_we = 1'b1;
        cnt_nxt  = '0;
        st_nxt   = fdc_pkg::S_CURL;
      end
      fdc_pkg::S_CURL: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          cnt_nxt = '0;
          st_nxt  = fdc_pkg::S_SAT;
        end
      end
      fdc_pkg::S_SAT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          st_nxt   = fdc_pkg::S_IDLE;
        end
      end
      default: begin
        st_nxt = fdc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    b_sel   = '0;
    rmu_sel = '0;
    case (cnt_r[1:0])
      2'd0: begin
        b_sel   = b_r[0];
        rmu_sel = mok_r[0] ? tabx_q : '0;
      end
      2'd1: begin
        b_sel   = b_r[1];
        rmu_sel = mok_r[1] ? taby_q : '0;
      end
      2'd2: begin
        b_sel   = b_r[2];
        rmu_sel = mok_r[2] ? tabz_q : '0;
      end
      default: begin
        b_sel   = '0;
        rmu_sel = '0;
      end
    endcase
  end

  always_comb begin
    coef_sel = '0;
    diff_sel = '0;
    case (cnt_r) inside
      3'd0, 3'd5: coef_sel = coef_y_r;
      3'd1, 3'd2: coef_sel = coef_z_r;
      3'd3, 3'd4: coef_sel = coef_x_r;
      default:    coef_sel = '0;
    endcase
    if (cnt_r < 3'd6) begin
      diff_sel = diff_r[cnt_r];
    end
  end

  assign term_j = cnt_r - 3'd1;
  assign sum_j  = 2'(term_j >> 1);

  always_ff @(posedge clk) begin
    if (voxel_acc) begin
      b_r[0] <= in_data.b_x;
      b_r[1] <= in_data.b_y;
      b_r[2] <= in_data.b_z;
      mok_r  <= {mz9 < 9'(N_MATERIALS), my9 < 9'(N_MATERIALS), mx9 < 9'(N_MATERIALS)};
    end
    if (st_r == fdc_pkg::S_PROD) begin
      if (cnt_r != 3'd3) begin
        mul_r <= b_sel * rmu_sel;
      end
      if (cnt_r != 3'd0) begin
        p_r[cnt_r[1:0] - 2'd1] <= sat_prod(mul_r);
      end
    end
    if (st_r == fdc_pkg::S_DIFF) begin
      diff_r[0] <= $signed({p_r[2][31], p_r[2]}) - $signed({row_q[31], row_q[31:0]});
      diff_r[1] <= $signed({p_r[1][31], p_r[1]}) - $signed({plane_q[31], plane_q[31:0]});
      diff_r[2] <= $signed({p_r[0][31], p_r[0]}) - $signed({plane_q[63], plane_q[63:32]});
      diff_r[3] <= $signed({p_r[2][31], p_r[2]}) - $signed({prev_b_r[31], prev_b_r});
      diff_r[4] <= $signed({p_r[1][31], p_r[1]}) - $signed({prev_a_r[31], prev_a_r});
      diff_r[5] <= $signed({p_r[0][31], p_r[0]}) - $signed({row_q[63], row_q[63:32]});
    end
    if (st_r == fdc_pkg::S_CURL) begin
      if (cnt_r < 3'd6) begin
        cm_r <= diff_sel * $signed({1'b0, coef_sel});
      end
      if (cnt_r != 3'd0) begin
        if (!term_j[0]) begin
          acc_r <= cm_r;
        end else begin
          sum_r[sum_j] <= $signed({acc_r[50], acc_r}) - $signed({cm_r[50], cm_r});
        end
      end
    end
    if (out_load) begin
      out_data_r.curl_x       <= ok ? sat_curl(sum_r[0]) : '0;
      out_data_r.curl_y       <= ok ? sat_curl(sum_r[1]) : '0;
      out_data_r.curl_z       <= ok ? sat_curl(sum_r[2]) : '0;
      out_data_r.neighbors_ok <= ok;
      out_data_r.at_x         <= 6'(pos_x_r);
      out_data_r.at_y         <= 6'(pos_y_r);
      out_data_r.at_z         <= 6'(pos_z_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      prev_a_r    <= '0;
      prev_b_r    <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == fdc_pkg::S_DIFF) begin
        prev_a_r <= p_r[1];
        prev_b_r <= p_r[2];
      end
      if (out_load) begin
        if (XCW'(pos_x_r) + XCW'(1) >= len_x) begin
          pos_x_r <= '0;
          if (YCW'(pos_y_r) + YCW'(1) >= len_y) begin
            pos_y_r <= '0;
            pos_z_r <= (ZCW'(pos_z_r) + ZCW'(1) >= len_z) ? '0 : pos_z_r + ZW'(1);
          end else begin
            pos_y_r <= pos_y_r + YW'(1);
          end
        end else begin
          pos_x_r <= pos_x_r + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r  <= '0;
      coef_y_r  <= '0;
      coef_z_r  <= '0;
      cells_x_r <= fdc_pkg::CELLS_RESET;
      cells_y_r <= fdc_pkg::CELLS_RESET;
      cells_z_r <= fdc_pkg::CELLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fdc_pkg::CFG_COEF_X:  coef_x_r  <= cfg_data[fdc_pkg::COEF_W-1:0];
        fdc_pkg::CFG_COEF_Y:  coef_y_r  <= cfg_data[fdc_pkg::COEF_W-1:0];
        fdc_pkg::CFG_COEF_Z:  coef_z_r  <= cfg_data[fdc_pkg::COEF_W-1:0];
        fdc_pkg::CFG_CELLS_X: cells_x_r <= cfg_data[fdc_pkg::CELLS_W-1:0];
        fdc_pkg::CFG_CELLS_Y: cells_y_r <= cfg_data[fdc_pkg::CELLS_W-1:0];
        fdc_pkg::CFG_CELLS_Z: cells_z_r <= cfg_data[fdc_pkg::CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/fdc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module fdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fdc_checker.sv =====
// Port-level assertions for the curl-of-B stencil and their bind to the top level.
module fdc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input fdc_pkg::out_item_t         out_data
);

  // reset starts the store clear, so no request is taken right after it
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("in_stall low right after reset");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.neighbors_ok |->
      out_data.curl_x == '0 && out_data.curl_y == '0 && out_data.curl_z == '0)
    else $error("nonzero curl on a boundary voxel");

  a_ok_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.neighbors_ok |->
      out_data.at_x != '0 && out_data.at_y != '0 && out_data.at_z != '0)
    else $error("neighbors_ok set at a boundary position");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind fdtd_curl_b_stencil fdc_checker u_fdc_checker (.*);

// ===== sim/fdtd_curl_b_stencil_test.sv =====
// Testbench for the curl-of-B stencil: directed and random requests checked against a predictor.
module fdtd_curl_b_stencil_test;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;
  localparam int RMU_ENTRIES = 16;
  localparam int FRAC = 16;
  localparam int SETTLE = 16;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CFG_W = fdc_pkg::CFG_DW;
  localparam int IDX_W = fdc_pkg::CFG_IW;
  localparam logic [CFG_W-1:0] COEF_ONE = 17'h10000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fdc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fdc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  fdtd_curl_b_stencil #(
    .MAX_X(GRID_X),
    .MAX_Y(GRID_Y),
    .MAX_Z(GRID_Z),
    .N_MATERIALS(RMU_ENTRIES),
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [31:0] rmu_x_tab [RMU_ENTRIES] = '{default: '0};
  logic signed [31:0] rmu_y_tab [RMU_ENTRIES] = '{default: '0};
  logic signed [31:0] rmu_z_tab [RMU_ENTRIES] = '{default: '0};
  logic signed [31:0] plane_px [GRID_X*GRID_Y] = '{default: '0};
  logic signed [31:0] plane_py [GRID_X*GRID_Y] = '{default: '0};
  logic signed [31:0] row_px [GRID_X] = '{default: '0};
  logic signed [31:0] row_pz [GRID_X] = '{default: '0};
  logic signed [31:0] prev_py = '0;
  logic signed [31:0] prev_pz = '0;
  int pos_x = 0;
  int pos_y = 0;
  int pos_z = 0;
  logic [fdc_pkg::COEF_W-1:0] coef_x = '0;
  logic [fdc_pkg::COEF_W-1:0] coef_y = '0;
  logic [fdc_pkg::COEF_W-1:0] coef_z = '0;
  logic [fdc_pkg::CELLS_W-1:0] cells_x = fdc_pkg::CELLS_RESET;
  logic [fdc_pkg::CELLS_W-1:0] cells_y = fdc_pkg::CELLS_RESET;
  logic [fdc_pkg::CELLS_W-1:0] cells_z = fdc_pkg::CELLS_RESET;

  fdc_pkg::out_item_t pending_curls [$];
  int mismatches = 0;
  int burst_left = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_tick = 0;
  logic [3:0] known_mats [4] = '{4'd0, 4'd15, 4'd7, 4'd8};

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(fdc_pkg::Q_MAX)) return fdc_pkg::Q_MAX;
    if (v < longint'(fdc_pkg::Q_MIN)) return fdc_pkg::Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] scaled_product(logic signed [31:0] b,
                                                       logic signed [31:0] r);
    longint p;
    p = longint'(b) * longint'(r);
    return sat32(p >>> FRAC);
  endfunction

  function automatic logic signed [31:0] curl_part(
      logic [fdc_pkg::COEF_W-1:0] c1, logic signed [31:0] a0, logic signed [31:0] a1,
      logic [fdc_pkg::COEF_W-1:0] c2, logic signed [31:0] b0, logic signed [31:0] b1);
    longint s;
    s = longint'(c1) * (longint'(a0) - longint'(a1))
      - longint'(c2) * (longint'(b0) - longint'(b1));
    return sat32(s >>> fdc_pkg::COEF_FRAC);
  endfunction

  function automatic int axis_span(logic [fdc_pkg::CELLS_W-1:0] c, int lim);
    if (c < 2) return 2;
    if (c > lim) return lim;
    return c;
  endfunction

  task automatic advance_stencil(input fdc_pkg::in_item_t r);
    logic signed [31:0] px, py, pz;
    fdc_pkg::out_item_t e;
    int pidx;
    if (r.cmd == fdc_pkg::CMD_LOAD) begin
      rmu_x_tab[r.load_index] = r.load_rmu_x;
      rmu_y_tab[r.load_index] = r.load_rmu_y;
      rmu_z_tab[r.load_index] = r.load_rmu_z;
    end else begin
      px = scaled_product(r.b_x, rmu_x_tab[r.mat_x]);
      py = scaled_product(r.b_y, rmu_y_tab[r.mat_y]);
      pz = scaled_product(r.b_z, rmu_z_tab[r.mat_z]);
      pidx = pos_y * GRID_X + pos_x;
      e = '0;
      e.neighbors_ok = (pos_x >= 1) && (pos_y >= 1) && (pos_z >= 1);
      if (e.neighbors_ok) begin
        e.curl_x = curl_part(coef_y, pz, row_pz[pos_x], coef_z, py, plane_py[pidx]);
        e.curl_y = curl_part(coef_z, px, plane_px[pidx], coef_x, pz, prev_pz);
        e.curl_z = curl_part(coef_x, py, prev_py, coef_y, px, row_px[pos_x]);
      end
      e.at_x = 6'(pos_x);
      e.at_y = 6'(pos_y);
      e.at_z = 6'(pos_z);
      pending_curls.push_back(e);
      prev_py = py;
      prev_pz = pz;
      row_px[pos_x] = px;
      row_pz[pos_x] = pz;
      plane_px[pidx] = px;
      plane_py[pidx] = py;
      if (pos_x + 1 >= axis_span(cells_x, GRID_X)) begin
        pos_x = 0;
        if (pos_y + 1 >= axis_span(cells_y, GRID_Y)) begin
          pos_y = 0;
          pos_z = (pos_z + 1 >= axis_span(cells_z, GRID_Z)) ? 0 : pos_z + 1;
        end else begin
          pos_y++;
        end
      end else begin
        pos_x++;
      end
    end
  endtask

  function automatic logic signed [31:0] random_q();
    int v;
    case ($urandom_range(0, 5))
      0: return fdc_pkg::Q_MAX;
      1: return fdc_pkg::Q_MIN;
      2, 3: return $urandom();
      default: begin
        v = int'($urandom_range(0, 262143)) - 131072;
        return v;
      end
    endcase
  endfunction

  function automatic fdc_pkg::in_item_t random_voxel(bit any_mat);
    fdc_pkg::in_item_t r;
    r.cmd = fdc_pkg::CMD_VOXEL;
    r.b_x = random_q();
    r.b_y = random_q();
    r.b_z = random_q();
    r.mat_x = any_mat ? 4'($urandom_range(0, 15)) : known_mats[$urandom_range(0, 3)];
    r.mat_y = any_mat ? 4'($urandom_range(0, 15)) : known_mats[$urandom_range(0, 3)];
    r.mat_z = any_mat ? 4'($urandom_range(0, 15)) : known_mats[$urandom_range(0, 3)];
    r.load_index = 4'($urandom_range(0, 15));
    r.load_rmu_x = $urandom();
    r.load_rmu_y = $urandom();
    r.load_rmu_z = $urandom();
    return r;
  endfunction

  function automatic fdc_pkg::in_item_t random_load(logic [3:0] idx);
    fdc_pkg::in_item_t r;
    r = random_voxel(1'b1);
    r.cmd = fdc_pkg::CMD_LOAD;
    r.load_index = idx;
    r.load_rmu_x = random_q();
    r.load_rmu_y = random_q();
    r.load_rmu_z = random_q();
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] random_coef();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return COEF_ONE;
      default: return CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_cells();
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 127));
    return CFG_W'($urandom_range(2, 6));
  endfunction

  function automatic string curl_text(fdc_pkg::out_item_t c);
    return $sformatf("curl=(%0d,%0d,%0d) ok=%0b at=(%0d,%0d,%0d)",
                     c.curl_x, c.curl_y, c.curl_z, c.neighbors_ok, c.at_x, c.at_y, c.at_z);
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_request(input fdc_pkg::in_item_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    advance_stencil(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_curls.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      fdc_pkg::CFG_COEF_X: coef_x = val;
      fdc_pkg::CFG_COEF_Y: coef_y = val;
      fdc_pkg::CFG_COEF_Z: coef_z = val;
      fdc_pkg::CFG_CELLS_X: cells_x = val[fdc_pkg::CELLS_W-1:0];
      fdc_pkg::CFG_CELLS_Y: cells_y = val[fdc_pkg::CELLS_W-1:0];
      fdc_pkg::CFG_CELLS_Z: cells_z = val[fdc_pkg::CELLS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_grid(input logic [CFG_W-1:0] kx, ky, kz, nx, ny, nz);
    write_reg(fdc_pkg::CFG_COEF_X, kx);
    write_reg(fdc_pkg::CFG_COEF_Y, ky);
    write_reg(fdc_pkg::CFG_COEF_Z, kz);
    write_reg(fdc_pkg::CFG_CELLS_X, nx);
    write_reg(fdc_pkg::CFG_CELLS_Y, ny);
    write_reg(fdc_pkg::CFG_CELLS_Z, nz);
    cfg_we <= 1'b0;
  endtask

  task automatic test_material_loads();
    fdc_pkg::in_item_t r;
    r = random_load(4'd0);
    r.load_rmu_x = 32'sh0001_0000;
    r.load_rmu_y = fdc_pkg::Q_MAX;
    r.load_rmu_z = fdc_pkg::Q_MIN;
    send_request(r);
    r = random_load(4'd15);
    r.load_rmu_x = fdc_pkg::Q_MAX;
    r.load_rmu_y = fdc_pkg::Q_MIN;
    r.load_rmu_z = 32'sh0001_0000;
    send_request(r);
    r = random_load(4'd7);
    r.load_rmu_x = fdc_pkg::Q_MIN;
    r.load_rmu_y = -32'sh0001_0000;
    r.load_rmu_z = fdc_pkg::Q_MAX;
    send_request(r);
    send_request(random_load(4'd8));
  endtask

  // full 2x2x2 grid at full coefficients, then one past the grid end
  task automatic test_grid_extremes();
    fdc_pkg::in_item_t r;
    drain_results();
    program_grid(COEF_ONE, COEF_ONE, COEF_ONE, 17'd2, 17'd2, 17'd2);
    for (int i = 0; i < 9; i++) begin
      r = random_voxel(1'b0);
      r.b_x = i[0] ? fdc_pkg::Q_MAX : fdc_pkg::Q_MIN;
      r.b_y = i[1] ? fdc_pkg::Q_MIN : fdc_pkg::Q_MAX;
      send_request(r);
    end
  endtask

  task automatic test_length_clamp();
    drain_results();
    program_grid(COEF_ONE, '0, 17'd32768, 17'd1, 17'd0, 17'd127);
    repeat (4) send_request(random_voxel(1'b0));
  endtask

  task automatic test_line_shrink();
    drain_results();
    program_grid(COEF_ONE, COEF_ONE, COEF_ONE, 17'd65, 17'd2, 17'd2);
    repeat (6) send_request(random_voxel(1'b0));
    drain_results();
    program_grid(17'd1, COEF_ONE, 17'd40000, 17'd3, 17'd2, 17'd2);
    repeat (3) send_request(random_voxel(1'b0));
  endtask

  task automatic run_random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 11) == 0) send_request(random_load(4'($urandom_range(0, 15))));
      else send_request(random_voxel(1'b1));
    end
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < RMU_ENTRIES; i++) send_request(random_load(4'(i)));
    for (int phase = 0; phase < 7; phase++) begin
      drain_results();
      case (phase)
        0: program_grid(COEF_ONE, COEF_ONE, COEF_ONE, 17'd2, 17'd2, 17'd2);
        1: program_grid('0, '0, '0, 17'd64, 17'd2, 17'd3);
        2: program_grid(COEF_ONE, '0, random_coef(), 17'd3, 17'd64, 17'd2);
        default: program_grid(random_coef(), random_coef(), random_coef(),
                              random_cells(), random_cells(), random_cells());
      endcase
      run_random_phase(140);
    end
  endtask

  task automatic test_output_holdoff();
    hold_request = 1'b1;
    repeat (20) send_request(random_voxel(1'b1));
  endtask

  task automatic test_sender_pause();
    run_random_phase(10);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_curls.size() != 0) @(posedge clk);
    run_random_phase(10);
  endtask

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case ((stall_tick / 256) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= (stall_tick % 7) < 3;
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    fdc_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_curls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", curl_text(out_data));
      end else begin
        want = pending_curls.pop_front();
        if (out_data.curl_x !== want.curl_x || out_data.curl_y !== want.curl_y ||
            out_data.curl_z !== want.curl_z ||
            out_data.neighbors_ok !== want.neighbors_ok ||
            out_data.at_x !== want.at_x || out_data.at_y !== want.at_y ||
            out_data.at_z !== want.at_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %s, got %s", curl_text(want), curl_text(out_data));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_material_loads();
    test_grid_extremes();
    test_length_clamp();
    test_line_shrink();
    test_random_stream();
    test_output_holdoff();
    test_sender_pause();
    drain_results();
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_curls.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
